// ===== hw/rtl/lldd_pkg.sv =====
// Package for the least-loaded job dispatcher.
// Holds sizes, codes, the job word and the shared helper functions.
// Depends on nothing; every module of the block but lldd_ram imports it.
`timescale 1ns / 1ps

package lldd_pkg;

    // Sizing of the block.
    localparam int NUM_WORKERS = 8;
    localparam int QUEUE_DEPTH = 16;
    localparam int LOAD_WIDTH  = 48;

    // Field widths fixed by the interface.
    localparam int CMD_W    = 1;
    localparam int TAG_W    = 16;
    localparam int SIZE_W   = 32;
    localparam int CFG_W    = 4;
    localparam int STATUS_W = 2;

    // Derived widths.
    localparam int WORKER_W = $clog2(NUM_WORKERS);
    localparam int NACT_W   = $clog2(NUM_WORKERS + 1);
    localparam int HEAD_W   = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int QADDR_W  = $clog2(NUM_WORKERS * QUEUE_DEPTH);
    localparam int NUM_LEAF = 2 ** WORKER_W;
    localparam int LEVELS   = WORKER_W;
    localparam int LEVEL_W  = $clog2(LEVELS + 1);

    // Depth of the job queue between front and back.
    localparam int JOBQ_DEPTH = 2;
    localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
    localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(NUM_WORKERS);

    // Command codes on the input word.
    localparam logic [CMD_W-1:0] CMD_PUT = 1'b0;
    localparam logic [CMD_W-1:0] CMD_GET = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_BAD   = 2'd3
    } t_status;

    // Operation class decided by the front.
    typedef enum logic [1:0] {
        OP_PUT,
        OP_GET,
        OP_BAD
    } t_op;

    // One classified job word as it sits in the job queue.
    typedef struct packed {
        t_op                 op;
        logic [TAG_W-1:0]    tag;
        logic [SIZE_W-1:0]   size;
        logic [WORKER_W-1:0] widx;
    } t_job;

    // Clamp the raw active-worker setting to 1..NUM_WORKERS.
    function automatic logic [NACT_W-1:0] eff_active(input logic [CFG_W-1:0] a);
        logic [NACT_W-1:0] n;
        if (a == '0) begin
            n = NACT_W'(1);
        end else if (int'(a) > NUM_WORKERS) begin
            n = NACT_W'(NUM_WORKERS);
        end else begin
            n = NACT_W'(a);
        end
        return n;
    endfunction

endpackage

// ===== hw/rtl/lldd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the per-worker tag queues.
`timescale 1ns / 1ps

module lldd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/lldd_front.sv =====
// Front of the dispatcher: accepts input words, classifies them and
// holds them in a two-entry job queue. Depends on lldd_pkg.
`timescale 1ns / 1ps

module lldd_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [lldd_pkg::CMD_W-1:0]     i_cmd,
    input  logic [lldd_pkg::TAG_W-1:0]     i_job_tag,
    input  logic [lldd_pkg::SIZE_W-1:0]    i_job_size,
    input  logic [lldd_pkg::WORKER_W-1:0]  i_worker_index,
    input  logic [lldd_pkg::NACT_W-1:0]    i_active,
    output logic                           o_job_valid,
    output lldd_pkg::t_job                 o_job,
    input  logic                           i_job_pop
);
    import lldd_pkg::*;

    t_job                  r_buf [JOBQ_DEPTH];
    logic [JOBQ_PTR_W-1:0] r_wp;
    logic [JOBQ_PTR_W-1:0] r_rp;
    logic [JOBQ_CNT_W-1:0] r_cnt;
    t_job                  job_in;
    logic                  push;

    // Classify the incoming word; a get from an inactive worker is marked bad.
    always_comb begin
        job_in.tag  = i_job_tag;
        job_in.size = i_job_size;
        job_in.widx = i_worker_index;
        if (i_cmd == CMD_PUT) begin
            job_in.op = OP_PUT;
        end else if (NACT_W'(i_worker_index) >= i_active) begin
            job_in.op = OP_BAD;
        end else begin
            job_in.op = OP_GET;
        end
    end

    assign o_in_ready  = (r_cnt != JOBQ_CNT_W'(JOBQ_DEPTH));
    assign push        = i_in_valid && o_in_ready;
    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_buf[r_rp];

    // Queue pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_job_pop) begin
                r_rp <= (r_rp == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !i_job_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!push && i_job_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= job_in;
        end
    end

endmodule

// ===== hw/rtl/lldd_back.sv =====
// Back of the dispatcher: runs one job at a time, picks the least-loaded
// worker with an iterated comparator tree, keeps loads and queue pointers,
// and drives the result register. Depends on lldd_pkg and lldd_ram.
`timescale 1ns / 1ps

module lldd_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [lldd_pkg::NACT_W-1:0]    i_active,
    input  logic                           i_job_valid,
    input  lldd_pkg::t_job                 i_job,
    output logic                           o_job_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [lldd_pkg::STATUS_W-1:0]  o_status,
    output logic [lldd_pkg::WORKER_W-1:0]  o_chosen_worker,
    output logic [lldd_pkg::TAG_W-1:0]     o_tag_out
);
    import lldd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_COMMIT,
        S_GET,
        S_READ
    } t_state;

    // One node of the selection tree: a worker, its scan position and load.
    typedef struct packed {
        logic                  valid;
        logic [WORKER_W-1:0]   idx;
        logic [WORKER_W-1:0]   pos;
        logic [LOAD_WIDTH-1:0] load;
    } t_node;

    // The later node wins if the earlier one is invalid, or on a strictly smaller
    // load, or on an earlier scan position at equal load.
    function automatic t_node pick(input t_node a, input t_node b);
        t_node w;
        w = a;
        if (b.valid && (!a.valid || (b.load < a.load)
                || ((b.load == a.load) && (b.pos < a.pos)))) begin
            w = b;
        end
        return w;
    endfunction

    t_state                r_state,  n_state;
    t_job                  r_job,    n_job;
    t_node                 r_node    [NUM_LEAF];
    t_node                 n_node    [NUM_LEAF];
    logic [LEVEL_W-1:0]    r_lvl,    n_lvl;
    logic [LOAD_WIDTH-1:0] r_load    [NUM_WORKERS];
    logic [LOAD_WIDTH-1:0] n_load    [NUM_WORKERS];
    logic [HEAD_W-1:0]     r_head    [NUM_WORKERS];
    logic [HEAD_W-1:0]     n_head    [NUM_WORKERS];
    logic [COUNT_W-1:0]    r_count   [NUM_WORKERS];
    logic [COUNT_W-1:0]    n_count   [NUM_WORKERS];
    logic [WORKER_W-1:0]   r_last,   n_last;
    logic                  r_out_valid, n_out_valid;
    t_status               r_status, n_status;
    logic [WORKER_W-1:0]   r_chosen, n_chosen;
    logic [TAG_W-1:0]      r_tag,    n_tag;

    logic                  can_emit;
    logic [WORKER_W-1:0]   start;
    logic [WORKER_W-1:0]   wsel;
    logic [HEAD_W-1:0]     sel_head;
    logic [COUNT_W-1:0]    sel_count;
    logic [HEAD_W:0]       slot_sum;
    logic [HEAD_W-1:0]     slot;
    logic [LOAD_WIDTH:0]   load_sum;
    logic [NACT_W:0]       pos_ext;
    logic                  ram_we;
    logic                  ram_re;
    logic [QADDR_W-1:0]    ram_waddr;
    logic [QADDR_W-1:0]    ram_raddr;
    logic [TAG_W-1:0]      ram_rdata;

    lldd_ram #(
        .WIDTH (TAG_W),
        .DEPTH (NUM_WORKERS * QUEUE_DEPTH)
    ) u_qram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_job.tag),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Scan start, and the worker whose queue the current job touches.
    assign start     = (NACT_W'(r_last) < i_active) ? r_last : '0;
    assign wsel      = (r_state == S_COMMIT) ? r_node[0].idx : r_job.widx;
    assign sel_head  = r_head[wsel];
    assign sel_count = r_count[wsel];
    assign can_emit  = !r_out_valid || i_out_ready;

    // Tail slot of the selected queue, wrapped once.
    always_comb begin
        slot_sum = (HEAD_W + 1)'(sel_head) + (HEAD_W + 1)'(sel_count);
        if (slot_sum >= (HEAD_W + 1)'(QUEUE_DEPTH)) begin
            slot = HEAD_W'(slot_sum - (HEAD_W + 1)'(QUEUE_DEPTH));
        end else begin
            slot = HEAD_W'(slot_sum);
        end
    end

    // Saturating load update for the chosen worker.
    assign load_sum  = {1'b0, r_node[0].load} + (LOAD_WIDTH + 1)'(r_job.size);
    assign ram_waddr = QADDR_W'(int'(wsel) * QUEUE_DEPTH + int'(slot));
    assign ram_raddr = QADDR_W'(int'(wsel) * QUEUE_DEPTH + int'(sel_head));

    // Next-state logic of the sequencer.
    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_node      = r_node;
        n_lvl       = r_lvl;
        n_load      = r_load;
        n_head      = r_head;
        n_count     = r_count;
        n_last      = r_last;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_chosen    = r_chosen;
        n_tag       = r_tag;
        o_job_pop   = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        pos_ext     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    unique case (i_job.op)
                        OP_BAD: begin
                            // An inactive worker index answers at once.
                            if (can_emit) begin
                                o_job_pop   = 1'b1;
                                n_out_valid = 1'b1;
                                n_status    = ST_BAD;
                                n_chosen    = i_job.widx;
                                n_tag       = '0;
                            end
                        end
                        OP_PUT: begin
                            // Load the tree leaves with loads and scan positions.
                            o_job_pop = 1'b1;
                            n_job     = i_job;
                            n_lvl     = '0;
                            for (int i = 0; i < NUM_LEAF; i++) begin
                                n_node[i].idx   = WORKER_W'(i);
                                n_node[i].valid = (i < NUM_WORKERS) && (i < int'(i_active));
                                n_node[i].load  = (i < NUM_WORKERS) ?
                                                  r_load[i % NUM_WORKERS] : '0;
                                if (WORKER_W'(i) >= start) begin
                                    pos_ext = (NACT_W + 1)'(WORKER_W'(i))
                                            - (NACT_W + 1)'(start);
                                end else begin
                                    pos_ext = (NACT_W + 1)'(WORKER_W'(i))
                                            + (NACT_W + 1)'(i_active)
                                            - (NACT_W + 1)'(start);
                                end
                                n_node[i].pos = WORKER_W'(pos_ext);
                            end
                            n_state = S_REDUCE;
                        end
                        OP_GET: begin
                            o_job_pop = 1'b1;
                            n_job     = i_job;
                            n_state   = S_GET;
                        end
                        default: begin
                            o_job_pop = 1'b0;
                        end
                    endcase
                end
            end

            S_REDUCE: begin
                // One tree level per cycle; the winner ends up in node zero.
                for (int j = 0; j < NUM_LEAF / 2; j++) begin
                    n_node[j] = pick(r_node[2 * j], r_node[2 * j + 1]);
                end
                n_lvl = r_lvl + 1'b1;
                if (r_lvl == LEVEL_W'(LEVELS - 1)) begin
                    n_state = S_COMMIT;
                end
            end

            S_COMMIT: begin
                if (can_emit) begin
                    n_last      = wsel;
                    n_out_valid = 1'b1;
                    n_chosen    = wsel;
                    n_tag       = '0;
                    if (sel_count == COUNT_W'(QUEUE_DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        n_status      = ST_OK;
                        ram_we        = 1'b1;
                        n_count[wsel] = sel_count + 1'b1;
                        n_load[wsel]  = load_sum[LOAD_WIDTH] ? '1 : load_sum[LOAD_WIDTH-1:0];
                    end
                    n_state = S_IDLE;
                end
            end

            S_GET: begin
                if (sel_count == '0) begin
                    if (can_emit) begin
                        n_out_valid = 1'b1;
                        n_status    = ST_EMPTY;
                        n_chosen    = wsel;
                        n_tag       = '0;
                        n_state     = S_IDLE;
                    end
                end else begin
                    // Pop the head; the tag arrives from the RAM next cycle.
                    ram_re        = 1'b1;
                    n_count[wsel] = sel_count - 1'b1;
                    n_head[wsel]  = (sel_head == HEAD_W'(QUEUE_DEPTH - 1)) ?
                                    '0 : sel_head + 1'b1;
                    n_state       = S_READ;
                end
            end

            S_READ: begin
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_chosen    = r_job.widx;
                    n_tag       = ram_rdata;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, worker bookkeeping and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_WORKERS; i++) begin
                r_load[i]  <= '0;
                r_head[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            r_load      <= n_load;
            r_head      <= n_head;
            r_count     <= n_count;
            r_job       <= n_job;
            r_node      <= n_node;
            r_lvl       <= n_lvl;
            r_status    <= n_status;
            r_chosen    <= n_chosen;
            r_tag       <= n_tag;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_chosen_worker = r_chosen;
    assign o_tag_out       = r_tag;

endmodule

// ===== hw/rtl/least_loaded_job_dispatcher_unit.sv =====
// Least-loaded job dispatcher. A put word goes to the active worker with the
// smallest accumulated load, scanning from the last chosen worker, and its tag
// is queued for that worker; a get word pops a tag from the named worker's
// queue. Every accepted word gives exactly one result word. The block works
// on one word at a time: a put passes level by level through the comparator
// tree, which resolves one level per cycle, and then commits; a get pops the
// queue and waits for the registered read of the queue RAM, or answers with
// an empty status when the queue is empty; a get of an inactive worker is
// answered from idle. A two-entry queue at the input and the result register
// let both sides stall on their own. Write the active-worker count only while
// the block is idle. Depends on lldd_pkg, lldd_front and lldd_back.
`timescale 1ns / 1ps

module least_loaded_job_dispatcher_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lldd_pkg::CFG_W-1:0]     i_cfg_active_workers,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [lldd_pkg::CMD_W-1:0]     i_cmd,
    input  logic [lldd_pkg::TAG_W-1:0]     i_job_tag,
    input  logic [lldd_pkg::SIZE_W-1:0]    i_job_size,
    input  logic [lldd_pkg::WORKER_W-1:0]  i_worker_index,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [lldd_pkg::STATUS_W-1:0]  o_status,
    output logic [lldd_pkg::WORKER_W-1:0]  o_chosen_worker,
    output logic [lldd_pkg::TAG_W-1:0]     o_tag_out
);
    import lldd_pkg::*;

    logic [CFG_W-1:0]  r_active;
    logic [NACT_W-1:0] active_eff;
    logic              job_valid;
    t_job              job;
    logic              job_pop;

    // Active-worker register; every write word is taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
        end else if (i_cfg_valid) begin
            r_active <= i_cfg_active_workers;
        end
    end

    assign active_eff = eff_active(r_active);

    lldd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_job_tag      (i_job_tag),
        .i_job_size     (i_job_size),
        .i_worker_index (i_worker_index),
        .i_active       (active_eff),
        .o_job_valid    (job_valid),
        .o_job          (job),
        .i_job_pop      (job_pop)
    );

    lldd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_active        (active_eff),
        .i_job_valid     (job_valid),
        .i_job           (job),
        .o_job_pop       (job_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_chosen_worker (o_chosen_worker),
        .o_tag_out       (o_tag_out)
    );

endmodule

// ===== hw/rtl/lldd_checker.sv =====
// Port-level checks for the least-loaded job dispatcher, bound to its top.
// Depends on lldd_pkg and least_loaded_job_dispatcher_unit.
`timescale 1ns / 1ps

module lldd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [lldd_pkg::STATUS_W-1:0]  o_status,
    input logic [lldd_pkg::WORKER_W-1:0]  o_chosen_worker,
    input logic [lldd_pkg::TAG_W-1:0]     o_tag_out
);
    import lldd_pkg::*;

    // At most two queued words, one in the back and one in the result register.
    localparam int MAX_PEND = JOBQ_DEPTH + 2;
    localparam int PEND_W   = $clog2(MAX_PEND + 2);

    logic [PEND_W-1:0] r_pend;
    logic              in_acc;
    logic              out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // Words accepted but not yet answered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (in_acc && !out_acc) begin
            r_pend <= r_pend + 1'b1;
        end else if (!in_acc && out_acc) begin
            r_pend <= r_pend - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid
            && $stable(o_status) && $stable(o_chosen_worker) && $stable(o_tag_out))
        else $error("result word changed while stalled");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pend != '0)
        else $error("result word without an accepted input word");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PEND_W'(MAX_PEND))
        else $error("more words in flight than the block can hold");

    a_tag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> o_tag_out == '0)
        else $error("nonzero tag on a failed request");

endmodule

bind least_loaded_job_dispatcher_unit lldd_checker u_lldd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_status        (o_status),
    .o_chosen_worker (o_chosen_worker),
    .o_tag_out       (o_tag_out)
);
